// ===== rtl/core/modular_exponentiation_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation core
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication
`define MODEXP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MODEXP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// Constants, types and unit interface structs for the modular exponentiator.
// ----------------------------------------------------------------------------
package modexp_pkg;

	localparam int unsigned EXP_BITS = 32;
	localparam int unsigned RES_W    = 30;

	typedef logic [RES_W-1:0]    res_t;
	typedef logic [EXP_BITS-1:0] exp_t;

	localparam res_t        MODULUS    = 30'd1000000033;
	localparam logic [30:0] MODULUS_X2 = 31'd2000000066;
	// floor(2^60 / MODULUS)
	localparam logic [30:0] BARRETT_MU = 31'd1152921466;
	// Fermat inverse exponent, MODULUS - 2
	localparam exp_t        INV_EXP    = exp_t'(32'd1000000031);
	localparam res_t        RES_ONE    = 30'd1;

	// result destination of a multiplier operation
	localparam logic TAG_SQ  = 1'b0;
	localparam logic TAG_ACC = 1'b1;

	typedef struct packed {
		logic valid;
		logic tag;
		res_t op_a;
		res_t op_b;
	} mm_req_t;

	typedef struct packed {
		logic valid;
		logic tag;
		res_t value;
	} mm_rsp_t;

endpackage

// ===== rtl/core/modexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// modexp_mulmod
// Five-stage pipelined modular multiplier, Barrett reduction by the prime.
// ----------------------------------------------------------------------------
module modexp_mulmod (
	input  logic                clk,
	input  logic                arst_n,
	input  modexp_pkg::mm_req_t req,
	output modexp_pkg::mm_rsp_t rsp
);

	logic [4:0]  valid_q;
	logic        tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [59:0] prod_s1;
	logic [61:0] q2_s2;
	logic [31:0] plo_s2, plo_s3;
	logic [31:0] qm_s3;
	logic [31:0] r_s4;
	modexp_pkg::res_t value_s5;

	logic [31:0] red_1m;
	logic [31:0] red_2m;
	modexp_pkg::res_t value_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[3:0], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: full product, below 2^60
		prod_s1  <= 60'(req.op_a) * 60'(req.op_b);
		tag_s1   <= req.tag;
		// stage 2: quotient estimate
		q2_s2    <= 62'(prod_s1[59:29]) * 62'(modexp_pkg::BARRETT_MU);
		plo_s2   <= prod_s1[31:0];
		tag_s2   <= tag_s1;
		// stage 3: only the low word of q*M matters, remainder is below 3M
		qm_s3    <= 32'(q2_s2[61:31]) * 32'(modexp_pkg::MODULUS);
		plo_s3   <= plo_s2;
		tag_s3   <= tag_s2;
		// stage 4
		r_s4     <= plo_s3 - qm_s3;
		tag_s4   <= tag_s3;
		// stage 5: final correction
		value_s5 <= value_d;
		tag_s5   <= tag_s4;
	end

	assign red_1m = r_s4 - 32'(modexp_pkg::MODULUS);
	assign red_2m = r_s4 - 32'(modexp_pkg::MODULUS_X2);

	always_comb begin
		if (r_s4 >= 32'(modexp_pkg::MODULUS_X2)) begin
			value_d = red_2m[modexp_pkg::RES_W-1:0];
		end else if (r_s4 >= 32'(modexp_pkg::MODULUS)) begin
			value_d = red_1m[modexp_pkg::RES_W-1:0];
		end else begin
			value_d = r_s4[modexp_pkg::RES_W-1:0];
		end
	end

	assign rsp.valid = valid_q[4];
	assign rsp.tag   = tag_s5;
	assign rsp.value = value_s5;

endmodule

// ===== rtl/core/modexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// modexp_ctrl
// Right-to-left square-and-multiply sequencer driving the shared multiplier.
// ----------------------------------------------------------------------------
module modexp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                req_type,
	input  logic [29:0]         base_value,
	input  logic [31:0]         exponent,
	output logic                busy,
	output logic                done,
	output logic [29:0]         residue,
	output modexp_pkg::mm_req_t iss,
	input  modexp_pkg::mm_rsp_t ret
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_SQ    = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [1:0]       pend_q, pend_d;
	modexp_pkg::exp_t e_q, e_d;
	modexp_pkg::res_t acc_q, acc_d;
	modexp_pkg::res_t sq_q, sq_d;
	logic             done_q, done_d;
	modexp_pkg::res_t residue_q, residue_d;
	modexp_pkg::res_t base_red;
	logic [29:0]      base_sub;

	assign base_sub = base_value - modexp_pkg::MODULUS;
	assign base_red = (base_value >= modexp_pkg::MODULUS) ? base_sub : base_value;

	always_comb begin
		state_d   = state_q;
		e_d       = e_q;
		acc_d     = acc_q;
		sq_d      = sq_q;
		done_d    = 1'b0;
		residue_d = residue_q;
		iss.valid = 1'b0;
		iss.tag   = modexp_pkg::TAG_SQ;
		iss.op_a  = sq_q;
		iss.op_b  = sq_q;

		// write back whatever the multiplier returns
		if (ret.valid) begin
			if (ret.tag == modexp_pkg::TAG_ACC) begin
				acc_d = ret.value;
			end else begin
				sq_d = ret.value;
			end
		end

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					sq_d    = base_red;
					acc_d   = modexp_pkg::RES_ONE;
					e_d     = req_type ? modexp_pkg::INV_EXP : modexp_pkg::exp_t'(exponent);
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (e_q == '0) begin
					done_d    = 1'b1;
					residue_d = acc_q;
					state_d   = ST_IDLE;
				end else if (e_q[0]) begin
					iss.valid = 1'b1;
					iss.tag   = modexp_pkg::TAG_ACC;
					iss.op_a  = acc_q;
					// no square needed past the top set bit
					state_d   = (e_q[modexp_pkg::EXP_BITS-1:1] != '0) ? ST_SQ : ST_WAIT;
				end else begin
					iss.valid = 1'b1;
					state_d   = ST_WAIT;
				end
			end
			ST_SQ: begin
				iss.valid = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (ret.valid && pend_q == 2'd1) begin
					e_d     = e_q >> 1;
					state_d = ST_ISSUE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		pend_d = pend_q + 2'(iss.valid) - 2'(ret.valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		e_q       <= e_d;
		acc_q     <= acc_d;
		sq_q      <= sq_d;
		residue_q <= residue_d;
	end

	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign residue = residue_q;

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// done pulses once every exponent bit is consumed: each bit below the highest set bit takes a
//   square, plus a multiply if the bit is set; the highest set bit takes only a multiply.
//   Inverse requests use a 30-bit exponent with 18 ones; exponent zero finishes without the multiplier.
// Every step waits on the 5-stage modular multiplier; a square and a multiply share it.
// One transaction at a time: a new start is taken in the cycle done is high; no stall.
// Reset (arst_n low) returns the sequencer to idle and drops any transaction in flight.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Modular power and Fermat inverse modulo the prime 1000000033.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_assert.svh"

module modular_exponentiation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [29:0] base_value,
	input  logic [31:0] exponent,
	output logic        done,
	output logic [29:0] residue
);

	modexp_pkg::mm_req_t iss;
	modexp_pkg::mm_rsp_t ret;

	modexp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.base_value (base_value),
		.exponent   (exponent),
		.busy       (busy),
		.done       (done),
		.residue    (residue),
		.iss        (iss),
		.ret        (ret)
	);

	modexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iss),
		.rsp    (ret)
	);

	`MODEXP_ASSERT_NOW(a_res_range, done, residue < modexp_pkg::MODULUS, "residue not reduced")
	`MODEXP_ASSERT_NOW(a_mm_range, ret.valid, ret.value < modexp_pkg::MODULUS, "mulmod out of range")
	`MODEXP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not busy")
	`MODEXP_ASSERT_NOW(a_done_idle, done, !busy && !iss.valid, "done while work in flight")

endmodule
